// ===== rtl/bst_pkg.sv =====
package bst_pkg;

	localparam int KEY_W     = 32;
	localparam int CNT_W     = 9;
	localparam int CAP_W     = 9;
	localparam int BSIZE_W   = 16;
	localparam int DEPTH_DEF = 256;
	// cells per gather group
	localparam int GRP       = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// what one cell hands to the gather tree
	typedef struct packed {
		logic             pred_hit;
		logic [KEY_W-1:0] pred_gap;
		logic             succ_hit;
		logic [KEY_W-1:0] succ_gap;
		logic [KEY_W-1:0] top_key;
	} span_t;

	localparam int SPAN_W = $bits(span_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_GATHER,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/bst_cell.sv =====
module bst_cell
	import bst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift_en,
	input  logic [KEY_W-1:0] key_new,
	input  logic [KEY_W-1:0] left_key,
	input  logic             left_valid,
	input  logic             left_gt,
	input  logic             right_gt,
	input  logic             right_valid,
	output logic [KEY_W-1:0] key_q,
	output logic             valid_q,
	output logic             gt,
	output span_t            span
);

	logic             pred_hit_q;
	logic             succ_hit_q;
	logic [KEY_W-1:0] pred_gap_q;
	logic [KEY_W-1:0] succ_gap_q;
	logic             is_pred;
	logic             is_succ;

	// empty cells sort above everything
	assign gt      = !valid_q || (key_q > key_new);
	assign is_succ = valid_q && gt && !left_gt;
	assign is_pred = !gt && right_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pred_hit_q <= 1'b0;
			succ_hit_q <= 1'b0;
		end else if (shift_en) begin
			if (left_gt) begin
				valid_q <= left_valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
			pred_hit_q <= is_pred;
			succ_hit_q <= is_succ;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			if (left_gt) begin
				key_q <= left_key;
			end else if (gt) begin
				key_q <= key_new;
			end
			pred_gap_q <= is_pred ? (key_new - key_q) : '0;
			succ_gap_q <= is_succ ? (key_q - key_new) : '0;
		end
	end

	always_comb begin
		span.pred_hit = pred_hit_q;
		span.pred_gap = pred_gap_q;
		span.succ_hit = succ_hit_q;
		span.succ_gap = succ_gap_q;
		// highest held value sits in the last valid cell
		span.top_key  = (valid_q && !right_valid) ? key_q : '0;
	end

endmodule

// ===== rtl/bst_gather.sv =====
module bst_gather
	import bst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  span_t cells [GRP],
	output span_t group_q
);

	logic [SPAN_W-1:0] acc;

	// at most one cell per field is nonzero, so OR selects it
	always_comb begin
		acc = '0;
		for (int i = 0; i < GRP; i++) begin
			acc = acc | cells[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
		end else if (en) begin
			group_q <= span_t'(acc);
		end
	end

endmodule

// ===== rtl/bounded_span_tracker.sv =====
// bounded_span_tracker
// Sorted store of signed 32-bit values with running shortest and longest span.
// Input channel: in_valid/in_ready with value, starts_batch, batch_size.
// Output channel: out_valid/out_ready with status, element_count, has_spans,
// shortest_span, longest_span; one result transaction per input transaction.
// Config channel: cfg_valid/cfg_ready with cfg_data = capacity (always ready);
// write it only while the block is idle.
// Operation: an accepted value is inserted into a chain of DEPTH cells (broadcast
// compare, neighbor shift), the neighbor gaps and the top value are collected
// through a two-level OR tree of GRP-cell groups, and the result is registered.
// A rejected value skips the shift and gather steps. One item is in flight at a
// time, so a new item is accepted only once the last one has passed through its
// steps: accept, shift, group gather, final fold into the output register.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and only the final stage waits when the receiver stalls.
// Reset: store empty, shortest gap all ones, no batch open, capacity 256.
module bounded_span_tracker
	import bst_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [KEY_W-1:0]   value,
	input  logic                      starts_batch,
	input  logic        [BSIZE_W-1:0] batch_size,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      status,
	output logic        [CNT_W-1:0]   element_count,
	output logic                      has_spans,
	output logic        [KEY_W-1:0]   shortest_span,
	output logic        [KEY_W-1:0]   longest_span,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic        [CAP_W-1:0]   cfg_data
);

	localparam int NG   = (DEPTH + GRP - 1) / GRP;
	localparam int PADN = NG * GRP;
	// wide enough for count plus any batch size
	localparam int SW   = BSIZE_W + 1;

	state_t state_q, state_d;

	logic [CAP_W-1:0]   capacity_q;
	logic [KEY_W-1:0]   key_q;
	logic               rej_q;
	logic [BSIZE_W-1:0] batch_left_q;
	logic               batch_rej_q;
	logic [CNT_W-1:0]   count_q;
	logic [KEY_W-1:0]   min_q;
	logic [KEY_W-1:0]   longest_q;

	logic               accept;
	logic               shift_en;
	logic               gather_en;
	logic               load_out;

	// cell chain wiring
	logic [KEY_W-1:0] cell_key   [DEPTH];
	logic             cell_valid [DEPTH];
	logic             cell_gt    [DEPTH];
	span_t            cell_span  [PADN];
	span_t            group_q    [NG];

	// admission decision
	logic [SW-1:0]      cnt_w;
	logic [SW-1:0]      cap_w;
	logic [SW-1:0]      n_w;
	logic               full;
	logic               rej_d;
	logic [BSIZE_W-1:0] batch_left_d;
	logic               batch_rej_d;

	// final fold
	logic [SPAN_W-1:0] fin_acc;
	span_t             fin;
	logic [KEY_W-1:0]  min_d;
	logic [KEY_W-1:0]  longest_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	// ---------------- chain of cells ----------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] lk;
		logic             lv;
		logic             lg;
		logic             rg;
		logic             rv;

		if (i == 0) begin : g_first
			assign lk = '0;
			assign lv = 1'b0;
			assign lg = 1'b0;
		end else begin : g_mid_l
			assign lk = cell_key[i-1];
			assign lv = cell_valid[i-1];
			assign lg = cell_gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rg = 1'b1;
			assign rv = 1'b0;
		end else begin : g_mid_r
			assign rg = cell_gt[i+1];
			assign rv = cell_valid[i+1];
		end

		bst_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (shift_en),
			.key_new    (key_q),
			.left_key   (lk),
			.left_valid (lv),
			.left_gt    (lg),
			.right_gt   (rg),
			.right_valid(rv),
			.key_q      (cell_key[i]),
			.valid_q    (cell_valid[i]),
			.gt         (cell_gt[i]),
			.span       (cell_span[i])
		);
	end

	// pad the last group with empty entries
	for (genvar i = DEPTH; i < PADN; i++) begin : g_pad
		assign cell_span[i] = '0;
	end

	// ---------------- first gather level ----------------
	for (genvar g = 0; g < NG; g++) begin : g_grp
		span_t grp_in [GRP];
		for (genvar j = 0; j < GRP; j++) begin : g_in
			assign grp_in[j] = cell_span[g*GRP + j];
		end

		bst_gather u_gather (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (gather_en),
			.cells  (grp_in),
			.group_q(group_q[g])
		);
	end

	// ---------------- admission ----------------
	always_comb begin
		cnt_w = SW'(count_q);
		cap_w = (SW'(capacity_q) > SW'(DEPTH)) ? SW'(DEPTH) : SW'(capacity_q);
		n_w   = (batch_size == '0) ? SW'(1) : SW'(batch_size);
		full  = (cnt_w >= cap_w);

		batch_left_d = batch_left_q;
		batch_rej_d  = batch_rej_q;
		priority if (starts_batch) begin
			// whole batch must fit, else the rest of it is dropped too
			batch_left_d = BSIZE_W'(n_w - SW'(1));
			batch_rej_d  = (cnt_w + n_w) > cap_w;
			rej_d        = batch_rej_d;
		end else if (batch_left_q != '0) begin
			batch_left_d = batch_left_q - BSIZE_W'(1);
			rej_d        = batch_rej_q || full;
		end else begin
			rej_d        = full;
		end
	end

	// ---------------- final fold and span update ----------------
	always_comb begin
		fin_acc = '0;
		for (int g = 0; g < NG; g++) begin
			fin_acc = fin_acc | group_q[g];
		end
		fin = span_t'(fin_acc);

		min_d = min_q;
		if (!rej_q) begin
			if (fin.pred_hit && (fin.pred_gap < min_d)) begin
				min_d = fin.pred_gap;
			end
			if (fin.succ_hit && (fin.succ_gap < min_d)) begin
				min_d = fin.succ_gap;
			end
		end
		// keys keep signed order, and their difference is the value difference
		longest_d = rej_q ? longest_q : (fin.top_key - cell_key[0]);
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		shift_en  = 1'b0;
		gather_en = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = rej_d ? ST_DONE : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				shift_en = 1'b1;
				state_d  = ST_GATHER;
			end
			ST_GATHER: begin
				gather_en = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				// wait here while the previous result is still unread
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_left_q <= '0;
			batch_rej_q  <= 1'b0;
			rej_q        <= 1'b0;
			count_q      <= '0;
			min_q        <= '1;
			longest_q    <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (accept) begin
				batch_left_q <= batch_left_d;
				batch_rej_q  <= batch_rej_d;
				rej_q        <= rej_d;
			end
			if (shift_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (load_out) begin
				min_q     <= min_d;
				longest_q <= longest_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {~value[KEY_W-1], value[KEY_W-2:0]};
		end
		if (load_out) begin
			status        <= rej_q;
			element_count <= count_q;
			has_spans     <= (count_q >= CNT_W'(2));
			shortest_span <= (count_q >= CNT_W'(2)) ? min_d : '0;
			longest_span  <= (count_q >= CNT_W'(2)) ? longest_d : '0;
		end
	end

endmodule
